/* hdl/imh_pkg.sv */
// Package: shared types and constants for the indexed min-heap.
package imh_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 8;
    localparam int VAL_W = 64;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_POP    = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_KLOOK,
        S_DECIDE,
        S_DROP_RD,
        S_DROP_WR,
        S_DROP_CHK,
        S_PUT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DN_CMP2,
        S_XCH,
        S_XCH2,
        S_AFTER,
        S_OUT,
        S_CLR
    } state_t;

    typedef enum logic [1:0] {
        NX_UP,
        NX_DN,
        NX_PUT,
        NX_DONE
    } next_t;

    function automatic logic val_less(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        val_less = $signed(a) < $signed(b);
    endfunction

endpackage

/* hdl/imh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/indexed_min_heap_core.sv */
// Top level: indexed binary min-heap with key-to-slot table.
//
// Input beats on s_axis carry one request: insert, update or pop-min.
// Each accepted beat yields exactly one result beat on m_axis carrying the
// popped key and value (zero unless a successful pop) and a status code.
// One request is in flight at a time. A status-only result passes through
// S_KLOOK and S_DECIDE to S_OUT; other requests also move entries by sift-up
// or sift-down, one level per exchange. An update removes the entry and then
// reinserts it. The slot memory has one read and one write port, so each
// exchange writes its two slots in two states, S_XCH and S_XCH2.
// After reset a clearing pass over all 2^KEY_BITS key-table entries marks
// every key absent in the key table; s_axis_tready stays low during it.
// When the receiver stalls, the result waits in the output register and
// the next request is taken once the result beat has gone.
module indexed_min_heap_core
    import imh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // req_type[1:0], item_key[9:2], item_value[73:10]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata   // out_key[7:0], out_value[71:8], status[74:72]
);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KD = 1 << KEY_BITS;
    localparam int TW = SW + 1;

    state_t state_reg, state_next;
    next_t  after_reg, after_next;
    logic               put_reg, put_next;
    logic [1:0]         req_reg, req_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [SW-1:0]      p_reg, p_next, c_reg, c_next;
    logic [KEY_BITS-1:0] pk_reg, pk_next, ck_reg, ck_next;
    logic [VAL_W-1:0]   pv_reg, pv_next, cv_reg, cv_next;
    logic [KEY_BITS-1:0] clr_reg, clr_next;
    logic [7:0]         okey_reg, okey_next;
    logic [VAL_W-1:0]   oval_reg, oval_next;
    logic [2:0]         ost_reg, ost_next;

    logic                we_s;
    logic [SW-1:0]       wa_s, ra_s;
    logic [KEY_BITS+VAL_W-1:0] wd_s, rd_s;
    logic                we_t;
    logic [KEY_BITS-1:0] wa_t, ra_t;
    logic [TW-1:0]       wd_t, rd_t;

    imh_ram #(.WIDTH(KEY_BITS + VAL_W), .DEPTH(CAPACITY)) u_slots (
        .aclk(aclk), .we(we_s), .waddr(wa_s), .wdata(wd_s), .raddr(ra_s), .rdata(rd_s)
    );
    imh_ram #(.WIDTH(TW), .DEPTH(KD)) u_ktab (
        .aclk(aclk), .we(we_t), .waddr(wa_t), .wdata(wd_t), .raddr(ra_t), .rdata(rd_t)
    );

    logic [KEY_BITS-1:0] rk;
    logic [VAL_W-1:0]    rv;
    logic [CW:0]         lch, rch;
    logic [SW-1:0]       par;
    assign rk  = rd_s[KEY_BITS+VAL_W-1:VAL_W];
    assign rv  = rd_s[VAL_W-1:0];
    assign lch = (CW+1)'({p_reg, 1'b1});
    assign rch = lch + 1'b1;
    assign par = SW'((p_reg - 1'b1) >> 1);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {5'd0, ost_reg, oval_reg, okey_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
        after_reg <= after_next;  put_reg <= put_next;
        req_reg <= req_next;  key_reg <= key_next;  val_reg <= val_next;
        p_reg <= p_next;  c_reg <= c_next;
        pk_reg <= pk_next;  ck_reg <= ck_next;
        pv_reg <= pv_next;  cv_reg <= cv_next;
        okey_reg <= okey_next;  oval_reg <= oval_next;  ost_reg <= ost_next;
    end

    always_comb begin
        state_next = state_reg;  after_next = after_reg;  put_next = put_reg;
        req_next = req_reg;  key_next = key_reg;  val_next = val_reg;
        cnt_next = cnt_reg;  p_next = p_reg;  c_next = c_reg;
        pk_next = pk_reg;  ck_next = ck_reg;  pv_next = pv_reg;  cv_next = cv_reg;
        clr_next = clr_reg;
        okey_next = okey_reg;  oval_next = oval_reg;  ost_next = ost_reg;
        we_s = 1'b0;  wa_s = p_reg;  wd_s = {pk_reg, pv_reg};  ra_s = p_reg;
        we_t = 1'b0;  wa_t = pk_reg;  wd_t = {1'b1, p_reg};  ra_t = key_reg;
        unique case (state_reg)
            S_CLR: begin
                we_t = 1'b1;  wa_t = clr_reg;  wd_t = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == KEY_BITS'(KD - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                req_next = s_axis_tdata[1:0];
                key_next = KEY_BITS'(s_axis_tdata[9:2]);
                val_next = s_axis_tdata[73:10];
                put_next = 1'b0;
                okey_next = '0;  oval_next = '0;  ost_next = ST_OK;
                if (s_axis_tvalid) state_next = S_KLOOK;
            end
            S_KLOOK: begin
                ra_s = '0;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                unique case (req_t'(req_reg))
                    REQ_INSERT: begin
                        if (rd_t[SW]) begin ost_next = ST_PRESENT; state_next = S_OUT; end
                        else if (cnt_reg == CW'(CAPACITY)) begin
                            ost_next = ST_FULL; state_next = S_OUT;
                        end else state_next = S_PUT;
                    end
                    REQ_UPDATE: begin
                        if (!rd_t[SW]) begin ost_next = ST_MISSING; state_next = S_OUT; end
                        else begin p_next = rd_t[SW-1:0]; state_next = S_DROP_RD; end
                    end
                    REQ_POP: begin
                        if (cnt_reg == '0) begin ost_next = ST_EMPTY; state_next = S_OUT; end
                        else begin
                            okey_next = 8'(rk);  oval_next = rv;  key_next = rk;
                            p_next = '0;  state_next = S_DROP_RD;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_DROP_RD: begin
                ra_s = SW'(cnt_reg - 1'b1);
                cnt_next = cnt_reg - 1'b1;
                state_next = S_DROP_WR;
            end
            S_DROP_WR: begin
                // move last entry into hole p; clear the removed key
                pk_next = rk;  pv_next = rv;
                we_t = 1'b1;
                wa_t = key_reg;
                wd_t = '0;
                if (CW'(p_reg) >= cnt_reg) begin
                    after_next = NX_DONE;  state_next = S_AFTER;
                end else begin
                    we_s = 1'b1;  wa_s = p_reg;  wd_s = {rk, rv};
                    ra_s = par;
                    state_next = S_DROP_CHK;
                end
            end
            S_DROP_CHK: begin
                we_t = 1'b1;  wa_t = pk_reg;  wd_t = {1'b1, p_reg};
                ra_s = par;
                if (p_reg != '0 && !val_less(rv, pv_reg)) state_next = S_UP_CMP;
                else state_next = S_DN_RD;
            end
            S_PUT: begin
                p_next = SW'(cnt_reg);  pk_next = key_reg;  pv_next = val_reg;
                we_s = 1'b1;  wa_s = SW'(cnt_reg);  wd_s = {key_reg, val_reg};
                we_t = 1'b1;  wa_t = key_reg;  wd_t = {1'b1, SW'(cnt_reg)};
                cnt_next = cnt_reg + 1'b1;
                put_next = 1'b1;
                after_next = NX_UP;
                state_next = S_UP_RD;
            end
            S_UP_RD: begin
                ra_s = par;
                if (p_reg == '0) begin after_next = NX_DONE; state_next = S_AFTER; end
                else state_next = S_UP_CMP;
            end
            S_UP_CMP: begin
                c_next = par;  ck_next = rk;  cv_next = rv;
                if (val_less(rv, pv_reg)) begin
                    after_next = NX_DONE;  state_next = S_AFTER;
                end else begin
                    after_next = NX_UP;  state_next = S_XCH;
                end
            end
            S_DN_RD: begin
                ra_s = SW'(lch);
                if (lch >= (CW+1)'(cnt_reg)) begin
                    after_next = NX_DONE;  state_next = S_AFTER;
                end else state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                // left child in rd_s; fetch the right one if it exists
                c_next = SW'(lch);  ck_next = rk;  cv_next = rv;
                if (rch >= (CW+1)'(cnt_reg)) begin
                    if (val_less(pv_reg, rv)) begin
                        after_next = NX_DONE;  state_next = S_AFTER;
                    end else begin
                        after_next = NX_DN;  state_next = S_XCH;
                    end
                end else begin
                    ra_s = SW'(rch);
                    state_next = S_DN_CMP2;
                end
            end
            S_DN_CMP2: begin
                if (!val_less(cv_reg, rv)) begin
                    c_next = SW'(rch);  ck_next = rk;  cv_next = rv;
                    if (val_less(pv_reg, rv)) begin
                        after_next = NX_DONE; state_next = S_AFTER;
                    end else begin after_next = NX_DN; state_next = S_XCH; end
                end else if (val_less(pv_reg, cv_reg)) begin
                    after_next = NX_DONE;  state_next = S_AFTER;
                end else begin
                    after_next = NX_DN;  state_next = S_XCH;
                end
            end
            S_XCH: begin
                we_s = 1'b1;  wa_s = p_reg;  wd_s = {ck_reg, cv_reg};
                we_t = 1'b1;  wa_t = ck_reg;  wd_t = {1'b1, p_reg};
                state_next = S_XCH2;
            end
            S_XCH2: begin
                we_s = 1'b1;  wa_s = c_reg;  wd_s = {pk_reg, pv_reg};
                we_t = 1'b1;  wa_t = pk_reg;  wd_t = {1'b1, c_reg};
                p_next = c_reg;
                c_next = '1;
                if (after_reg == NX_UP) state_next = S_UP_RD;
                else state_next = S_DN_RD;
            end
            S_AFTER: begin
                if (req_reg == REQ_UPDATE && !put_reg) state_next = S_PUT;
                else state_next = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
